### design/qrep_pkg.sv
`default_nettype none
package qrep_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_MULT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ZERO      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_MULT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ZERO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZERO      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_INV_SCALE = 3'd5;

    localparam logic [23:0] RST_COS_MULT      = 24'd258;
    localparam logic [7:0]  RST_COS_ZERO      = 8'd128;
    localparam logic [23:0] RST_SIN_MULT      = 24'd258;
    localparam logic [7:0]  RST_SIN_ZERO      = 8'd128;
    localparam logic [7:0]  RST_OUT_ZERO      = 8'd128;
    localparam logic [31:0] RST_OUT_INV_SCALE = 32'd65536;

    localparam int ROT_STAGES = 5;
    localparam int REQ_STAGES = 4;
    localparam int NUM_STAGES = ROT_STAGES + REQ_STAGES;

    localparam int MAG_W  = 42;
    localparam int GAIN_W = 64;

    localparam logic [7:0] CODE_MAX = 8'd255;

    typedef struct packed {
        logic [23:0] cos_mult;
        logic [7:0]  cos_zero_point;
        logic [23:0] sin_mult;
        logic [7:0]  sin_zero_point;
        logic [7:0]  out_zero_point;
        logic [31:0] out_inverse_scale;
    } t_cfg;

endpackage
`default_nettype wire

### design/qrep_ctrl.sv
`default_nettype none
module qrep_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output logic [qrep_pkg::NUM_STAGES-1:0] o_en
);
    import qrep_pkg::*;

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_comb begin
        n_v[0] = en[0] ? i_valid : r_v[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_en        = en;
    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NUM_STAGES-1];

endmodule
`default_nettype wire

### design/qrep_rotate.sv
`default_nettype none
module qrep_rotate (
    input  logic                            i_clk,
    input  logic [qrep_pkg::ROT_STAGES-1:0] i_en,
    input  qrep_pkg::t_cfg                  i_cfg,
    input  logic [7:0]                      i_first_value,
    input  logic [7:0]                      i_second_value,
    input  logic [7:0]                      i_cos_value,
    input  logic [7:0]                      i_sin_value,
    input  logic [7:0]                      i_in_zero_point,
    input  logic [31:0]                     i_in_scale,
    output logic [qrep_pkg::MAG_W-1:0]      o_mag0,
    output logic                            o_neg0,
    output logic [qrep_pkg::MAG_W-1:0]      o_mag1,
    output logic                            o_neg1,
    output logic [qrep_pkg::GAIN_W-1:0]     o_gain
);
    import qrep_pkg::*;

    logic signed [8:0]   n1_a, n1_b, n1_dc, n1_ds;
    logic [GAIN_W-1:0]   n1_gain;
    logic signed [8:0]   r1_a, r1_b, r1_dc, r1_ds;
    logic [GAIN_W-1:0]   r1_gain;

    logic signed [33:0]  n2_c, n2_s;
    logic signed [8:0]   r2_a, r2_b;
    logic signed [32:0]  r2_c, r2_s;
    logic [GAIN_W-1:0]   r2_gain;

    logic signed [42:0]  n3_ac, n3_bs, n3_as, n3_bc;
    logic signed [42:0]  r3_ac, r3_bs, r3_as, r3_bc;
    logic [GAIN_W-1:0]   r3_gain;

    logic signed [42:0]  r4_t0, r4_t1;
    logic [GAIN_W-1:0]   r4_gain;

    logic signed [42:0]  n5_abs0, n5_abs1;
    logic [MAG_W-1:0]    r5_mag0, r5_mag1;
    logic                r5_neg0, r5_neg1;
    logic [GAIN_W-1:0]   r5_gain;

    always_comb begin
        n1_a    = $signed({1'b0, i_first_value})  - $signed({1'b0, i_in_zero_point});
        n1_b    = $signed({1'b0, i_second_value}) - $signed({1'b0, i_in_zero_point});
        n1_dc   = $signed({1'b0, i_cos_value}) - $signed({1'b0, i_cfg.cos_zero_point});
        n1_ds   = $signed({1'b0, i_sin_value}) - $signed({1'b0, i_cfg.sin_zero_point});
        n1_gain = i_in_scale * i_cfg.out_inverse_scale;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_a    <= n1_a;
            r1_b    <= n1_b;
            r1_dc   <= n1_dc;
            r1_ds   <= n1_ds;
            r1_gain <= n1_gain;
        end
    end

    always_comb begin
        n2_c = r1_dc * $signed({1'b0, i_cfg.cos_mult});
        n2_s = r1_ds * $signed({1'b0, i_cfg.sin_mult});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_c    <= n2_c[32:0];
            r2_s    <= n2_s[32:0];
            r2_gain <= r1_gain;
        end
    end

    always_comb begin
        n3_ac = r2_a * r2_c;
        n3_bs = r2_b * r2_s;
        n3_as = r2_a * r2_s;
        n3_bc = r2_b * r2_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_ac   <= n3_ac;
            r3_bs   <= n3_bs;
            r3_as   <= n3_as;
            r3_bc   <= n3_bc;
            r3_gain <= r2_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_t0   <= r3_ac - r3_bs;
            r4_t1   <= r3_as + r3_bc;
            r4_gain <= r3_gain;
        end
    end

    always_comb begin
        n5_abs0 = r4_t0[42] ? -r4_t0 : r4_t0;
        n5_abs1 = r4_t1[42] ? -r4_t1 : r4_t1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_mag0 <= n5_abs0[MAG_W-1:0];
            r5_mag1 <= n5_abs1[MAG_W-1:0];
            r5_neg0 <= r4_t0[42];
            r5_neg1 <= r4_t1[42];
            r5_gain <= r4_gain;
        end
    end

    assign o_mag0 = r5_mag0;
    assign o_neg0 = r5_neg0;
    assign o_mag1 = r5_mag1;
    assign o_neg1 = r5_neg1;
    assign o_gain = r5_gain;

endmodule
`default_nettype wire

### design/qrep_requant.sv
`default_nettype none
module qrep_requant (
    input  logic                            i_clk,
    input  logic [qrep_pkg::REQ_STAGES-1:0] i_en,
    input  logic [qrep_pkg::MAG_W-1:0]      i_mag,
    input  logic                            i_neg,
    input  logic [qrep_pkg::GAIN_W-1:0]     i_gain,
    input  logic [7:0]                      i_out_zero_point,
    output logic [7:0]                      o_result,
    output logic                            o_sat
);
    import qrep_pkg::*;

    logic [63:0]         r6_p0, r6_p1;
    logic [41:0]         r6_p2, r6_p3;
    logic                r6_neg;

    logic [105:0]        r7_base;
    logic [64:0]         r7_mid;
    logic                r7_neg;

    logic [105:0]        n8_full;
    logic                r8_big, r8_guard, r8_sticky, r8_neg;
    logic [7:0]          r8_q;

    logic                n9_inc;
    logic [8:0]          n9_q;
    logic signed [10:0]  n9_sum;
    logic [7:0]          n9_result;
    logic                n9_sat;
    logic [7:0]          r9_result;
    logic                r9_sat;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r6_p0  <= i_mag[31:0]  * i_gain[31:0];
            r6_p1  <= i_mag[31:0]  * i_gain[63:32];
            r6_p2  <= i_mag[41:32] * i_gain[31:0];
            r6_p3  <= i_mag[41:32] * i_gain[63:32];
            r6_neg <= i_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r7_base <= {r6_p3, r6_p0};
            r7_mid  <= {1'b0, r6_p1} + {23'b0, r6_p2};
            r7_neg  <= r6_neg;
        end
    end

    assign n8_full = r7_base + {9'b0, r7_mid, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r8_big    <= |n8_full[105:64];
            r8_q      <= n8_full[63:56];
            r8_guard  <= n8_full[55];
            r8_sticky <= |n8_full[54:0];
            r8_neg    <= r7_neg;
        end
    end

    always_comb begin
        n9_inc = r8_guard && (r8_sticky || r8_q[0]);
        n9_q   = {1'b0, r8_q} + {8'b0, n9_inc};
        if (r8_neg) begin
            n9_sum = $signed({3'b0, i_out_zero_point}) - $signed({2'b0, n9_q});
        end else begin
            n9_sum = $signed({3'b0, i_out_zero_point}) + $signed({2'b0, n9_q});
        end
        if (r8_big) begin
            n9_result = r8_neg ? 8'd0 : CODE_MAX;
            n9_sat    = 1'b1;
        end else if (n9_sum < 0) begin
            n9_result = 8'd0;
            n9_sat    = 1'b1;
        end else if (n9_sum > $signed({3'b0, CODE_MAX})) begin
            n9_result = CODE_MAX;
            n9_sat    = 1'b1;
        end else begin
            n9_result = n9_sum[7:0];
            n9_sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r9_result <= n9_result;
            r9_sat    <= n9_sat;
        end
    end

    assign o_result = r9_result;
    assign o_sat    = r9_sat;

endmodule
`default_nettype wire

### design/quantized_rotary_embedding_pair.sv
// Pipeline: a request passes from the edge that accepts it to o_valid through nine register
// stages: five rotation stages (dequant, scale multiply, four cross products, add,
// magnitude) and four requant stages (partial products, two summing stages, round and clamp).
// One request per cycle unless i_ready stalls; a full stage holds only while the next holds.
// Reset (synchronous, active low): clears all valid bits and loads the register defaults.
`default_nettype none
module quantized_rotary_embedding_pair (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_first_value,
    input  logic [7:0]                      i_second_value,
    input  logic [7:0]                      i_cos_value,
    input  logic [7:0]                      i_sin_value,
    input  logic [7:0]                      i_in_zero_point,
    input  logic [31:0]                     i_in_scale,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_first_result,
    output logic [7:0]                      o_second_result,
    output logic [1:0]                      o_saturated_count,
    input  logic                            i_cfg_we,
    input  logic [qrep_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qrep_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qrep_pkg::*;

    t_cfg                  r_cfg;
    logic [NUM_STAGES-1:0] en;
    logic [MAG_W-1:0]      mag0, mag1;
    logic                  neg0, neg1;
    logic [GAIN_W-1:0]     gain;
    logic                  sat0, sat1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_mult          <= RST_COS_MULT;
            r_cfg.cos_zero_point    <= RST_COS_ZERO;
            r_cfg.sin_mult          <= RST_SIN_MULT;
            r_cfg.sin_zero_point    <= RST_SIN_ZERO;
            r_cfg.out_zero_point    <= RST_OUT_ZERO;
            r_cfg.out_inverse_scale <= RST_OUT_INV_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COS_MULT:      r_cfg.cos_mult          <= i_cfg_data[23:0];
                CFG_COS_ZERO:      r_cfg.cos_zero_point    <= i_cfg_data[7:0];
                CFG_SIN_MULT:      r_cfg.sin_mult          <= i_cfg_data[23:0];
                CFG_SIN_ZERO:      r_cfg.sin_zero_point    <= i_cfg_data[7:0];
                CFG_OUT_ZERO:      r_cfg.out_zero_point    <= i_cfg_data[7:0];
                CFG_OUT_INV_SCALE: r_cfg.out_inverse_scale <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    qrep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_en        (en)
    );

    qrep_rotate u_rotate (
        .i_clk           (i_clk),
        .i_en            (en[ROT_STAGES-1:0]),
        .i_cfg           (r_cfg),
        .i_first_value   (i_first_value),
        .i_second_value  (i_second_value),
        .i_cos_value     (i_cos_value),
        .i_sin_value     (i_sin_value),
        .i_in_zero_point (i_in_zero_point),
        .i_in_scale      (i_in_scale),
        .o_mag0          (mag0),
        .o_neg0          (neg0),
        .o_mag1          (mag1),
        .o_neg1          (neg1),
        .o_gain          (gain)
    );

    qrep_requant u_requant0 (
        .i_clk            (i_clk),
        .i_en             (en[NUM_STAGES-1:ROT_STAGES]),
        .i_mag            (mag0),
        .i_neg            (neg0),
        .i_gain           (gain),
        .i_out_zero_point (r_cfg.out_zero_point),
        .o_result         (o_first_result),
        .o_sat            (sat0)
    );

    qrep_requant u_requant1 (
        .i_clk            (i_clk),
        .i_en             (en[NUM_STAGES-1:ROT_STAGES]),
        .i_mag            (mag1),
        .i_neg            (neg1),
        .i_gain           (gain),
        .i_out_zero_point (r_cfg.out_zero_point),
        .o_result         (o_second_result),
        .o_sat            (sat1)
    );

    assign o_saturated_count = {1'b0, sat0} + {1'b0, sat1};

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline refuses a request while its output is empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_saturated_count != 2'd3)
        else $error("saturation count out of range");

    a_sat_at_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated_count == 2'd2 |->
            (o_first_result == 8'd0 || o_first_result == CODE_MAX) &&
            (o_second_result == 8'd0 || o_second_result == CODE_MAX))
        else $error("clamped result not at a rail");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
